### rtl/psched_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority scheduler package
// Shared types and codes of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package psched_pkg;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam int PID_W  = 8;
    localparam int TIME_W = 16;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] tick_time;
        logic              finished;
        logic [PID_W-1:0]  ran_pid;
        logic              ran_valid;
        logic              accepted;
    } result_t;

endpackage
`default_nettype wire

### rtl/psched_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module psched_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/preemptive_priority_scheduler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Preemptive priority scheduler core
// Ready table in one RAM; an arrive item appends a task, a tick item runs
// the highest priority task for one time unit.
// ----------------------------------------------------------------------------
// The ready table lives in a single RAM word per task. An arrive item with
// a zero burst or for a full table is refused. An arrive item, and a tick
// item that finds the table empty, go straight to the result state. Any
// other tick item scans the table through the RAM read port, one entry per
// cycle; when the task finishes, the later entries are moved down one
// place through the same port. A new item is accepted while the previous
// result still waits in the output register.
module preemptive_priority_scheduler_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PRIO_BITS   = 8,
    parameter int BURST_BITS  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: new_pid[7:0], new_priority[15:8], new_burst[31:16].
    input  wire logic [31:0] s_tdata,
    // Fields from bit 0: func.
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: accepted, ran_valid, ran_pid[9:2], finished,
    // tick_time[26:11], zero padding.
    output logic [31:0]      m_tdata
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PID_W  = psched_pkg::PID_W;
    localparam int WORD_W = PID_W + PRIO_BITS + BURST_BITS;
    localparam int RES_W  = $bits(psched_pkg::result_t);
    localparam int PAD_W  = 32 - RES_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    psched_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]                count_reg, count_next;
    logic [psched_pkg::TIME_W-1:0]   time_reg, time_next;
    logic [CNT_W-1:0]                rd_ptr_reg, rd_ptr_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]                pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]                best_idx_reg, best_idx_next;
    logic [PID_W-1:0]                best_pid_reg, best_pid_next;
    logic [PRIO_BITS-1:0]            best_prio_reg, best_prio_next;
    logic [BURST_BITS-1:0]           best_rem_reg, best_rem_next;
    psched_pkg::result_t             res_reg, res_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    psched_pkg::result_t             m_res_reg, m_res_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [WORD_W-1:0]      wr_data;
    logic [IDX_W-1:0]       rd_addr;
    logic [WORD_W-1:0]      rd_data;

    logic [PID_W-1:0]       in_pid;
    logic [PRIO_BITS-1:0]   in_prio;
    logic [BURST_BITS-1:0]  in_burst;
    logic [PRIO_BITS-1:0]   rd_prio;
    logic [BURST_BITS-1:0]  rem_dec;
    logic [CNT_W-1:0]       best_succ;
    logic                   in_accept;

    assign in_pid    = s_tdata[7:0];
    assign in_prio   = PRIO_BITS'(s_tdata[15:8]);
    assign in_burst  = BURST_BITS'(s_tdata[31:16]);
    assign rd_prio   = rd_data[BURST_BITS +: PRIO_BITS];
    assign rem_dec   = best_rem_reg - BURST_BITS'(1);
    assign best_succ = CNT_W'(best_idx_reg) + CNT_W'(1);
    assign s_tready  = (state_reg == psched_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{PAD_W{1'b0}}, m_res_reg};

    psched_ram #(
        .WIDTH(WORD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        time_next       = time_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        best_idx_next   = best_idx_reg;
        best_pid_next   = best_pid_reg;
        best_prio_next  = best_prio_reg;
        best_rem_next   = best_rem_reg;
        res_next        = res_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_res_next      = m_res_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = {in_pid, in_prio, in_burst};
        rd_addr         = rd_ptr_reg[IDX_W-1:0];

        case (state_reg)
            psched_pkg::ST_IDLE: begin
                if (in_accept) begin
                    res_next    = '0;
                    rd_ptr_next = '0;
                    state_next  = psched_pkg::ST_DONE;
                    if (s_tuser == psched_pkg::FUNC_ARRIVE) begin
                        if (in_burst != '0 && count_reg < DEPTH_CNT) begin
                            wr_en             = 1'b1;
                            count_next        = count_reg + CNT_W'(1);
                            res_next.accepted = 1'b1;
                        end
                    end else begin
                        time_next          = time_reg + psched_pkg::TIME_W'(1);
                        res_next.tick_time = time_next;
                        if (count_reg != '0) begin
                            state_next = psched_pkg::ST_SCAN;
                        end
                    end
                end
            end
            psched_pkg::ST_SCAN: begin
                if (rd_ptr_reg < count_reg) begin
                    rd_ptr_next     = rd_ptr_reg + CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rd_ptr_reg;
                end
                if (pend_valid_reg) begin
                    if (pend_idx_reg == '0 || rd_prio < best_prio_reg) begin
                        best_idx_next  = pend_idx_reg[IDX_W-1:0];
                        best_pid_next  = rd_data[BURST_BITS + PRIO_BITS +: PID_W];
                        best_prio_next = rd_prio;
                        best_rem_next  = rd_data[BURST_BITS-1:0];
                    end
                end else if (rd_ptr_reg >= count_reg) begin
                    state_next = psched_pkg::ST_UPDATE;
                end
            end
            psched_pkg::ST_UPDATE: begin
                res_next.ran_valid = 1'b1;
                res_next.ran_pid   = best_pid_reg;
                state_next         = psched_pkg::ST_DONE;
                if (rem_dec != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = best_idx_reg;
                    wr_data = {best_pid_reg, best_prio_reg, rem_dec};
                end else begin
                    res_next.finished = 1'b1;
                    count_next        = count_reg - CNT_W'(1);
                    if (best_succ < count_reg) begin
                        rd_addr         = best_succ[IDX_W-1:0];
                        rd_ptr_next     = best_succ + CNT_W'(1);
                        pend_valid_next = 1'b1;
                        pend_idx_next   = best_succ;
                        state_next      = psched_pkg::ST_SHIFT;
                    end
                end
            end
            psched_pkg::ST_SHIFT: begin
                if (pend_valid_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = IDX_W'(pend_idx_reg - CNT_W'(1));
                    wr_data = rd_data;
                end
                if (rd_ptr_reg <= count_reg) begin
                    rd_ptr_next     = rd_ptr_reg + CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rd_ptr_reg;
                end else if (!pend_valid_reg) begin
                    state_next = psched_pkg::ST_DONE;
                end
            end
            psched_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_res_next    = res_reg;
                    state_next    = psched_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = psched_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= psched_pkg::ST_IDLE;
            count_reg      <= '0;
            time_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            time_reg       <= time_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        rd_ptr_reg    <= rd_ptr_next;
        pend_idx_reg  <= pend_idx_next;
        best_idx_reg  <= best_idx_next;
        best_pid_reg  <= best_pid_next;
        best_prio_reg <= best_prio_next;
        best_rem_reg  <= best_rem_next;
        res_reg       <= res_next;
        m_res_reg     <= m_res_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("ready count exceeds table depth");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psched_pkg::ST_SCAN) |-> !wr_en)
        else $error("table written during priority scan");

    a_shift_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psched_pkg::ST_SHIFT && wr_en && rd_ptr_reg <= count_reg)
        |-> (wr_addr != rd_addr))
        else $error("shift reads and writes the same entry");

    a_arrive_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_res_reg.accepted)
        |-> (!m_res_reg.ran_valid && !m_res_reg.finished))
        else $error("arrive result carries tick fields");

    a_finish_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psched_pkg::ST_UPDATE && rem_dec == '0)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("finished task not removed from the table");

endmodule
`default_nettype wire

### tb/sv/tb_preemptive_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// Testbench for the preemptive priority scheduler core
// Drives arrive and tick items through the input stream and checks every
// result item against a cycle-free model of the ready table kept here. A
// short directed part covers refusals, a full table, ties and idle ticks;
// random items come under changing amounts of idling on both streams.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler_core;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 200;

    typedef struct {
        logic        func;
        logic [7:0]  pid;
        logic [7:0]  prio;
        logic [15:0] burst;
        int          phase;
    } sched_item_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    sched_item_t         pending_items[$];
    psched_pkg::result_t expected_results[$];
    sched_item_t         drv_item;
    int          rx_phase = 0;
    int          tx_idle_pct[3] = '{34, 57, 0};
    int          rx_idle_pct[3] = '{57, 34, 0};
    int          error_count = 0;
    int          items_checked = 0;
    int          cycle_count = 0;

    logic [7:0]  tbl_pid[TABLE_DEPTH];
    logic [7:0]  tbl_prio[TABLE_DEPTH];
    logic [15:0] tbl_left[TABLE_DEPTH];
    int          tbl_count = 0;
    logic [15:0] sched_time = '0;

    int          n_stored = 0;
    int          n_refused = 0;
    int          n_ran = 0;
    int          n_idle = 0;
    int          n_done = 0;
    int          n_wraps = 0;

    preemptive_priority_scheduler_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic add_item(input logic func, input logic [7:0] pid, input logic [7:0] prio,
                            input logic [15:0] burst, input int phase);
        sched_item_t it;
        it.func  = func;
        it.pid   = pid;
        it.prio  = prio;
        it.burst = burst;
        it.phase = phase;
        pending_items.push_back(it);
    endtask

    // Mostly arrive-then-run sequences with small bursts and close priorities,
    // mixed with table fills, long drains, refused arrives and raw noise.
    task automatic add_random_items(input int phase, input int count);
        int added;
        int sel;
        int n;
        logic [15:0] burst;
        added = 0;
        while (added < count) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
                n = $urandom_range(6, 1);
                repeat (n) begin
                    burst = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                     : 16'($urandom_range(8, 1));
                    add_item(psched_pkg::FUNC_ARRIVE, 8'($urandom), 8'($urandom_range(3)),
                             burst, phase);
                end
                added += n;
                n = $urandom_range(12, 1);
                repeat (n) add_item(psched_pkg::FUNC_TICK, 8'($urandom), 8'($urandom),
                                    16'($urandom), phase);
                added += n;
            end else if (sel < 65) begin
                repeat (18) add_item(psched_pkg::FUNC_ARRIVE, 8'($urandom), 8'($urandom),
                                     16'($urandom_range(4, 1)), phase);
                added += 18;
            end else if (sel < 75) begin
                n = $urandom_range(40, 20);
                repeat (n) add_item(psched_pkg::FUNC_TICK, 8'($urandom), 8'($urandom),
                                    16'($urandom), phase);
                added += n;
            end else if (sel < 85) begin
                add_item(1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), phase);
                added++;
            end else begin
                n = $urandom_range(3, 1);
                repeat (n) add_item(psched_pkg::FUNC_ARRIVE, 8'($urandom), 8'($urandom),
                                    16'h0000, phase);
                added += n;
            end
        end
    endtask

    task automatic predict_result(input sched_item_t it);
        psched_pkg::result_t res;
        int best;
        int k;
        res = '0;
        if (it.func == psched_pkg::FUNC_ARRIVE) begin
            if (it.burst != 16'h0000 && tbl_count < TABLE_DEPTH) begin
                tbl_pid[tbl_count]  = it.pid;
                tbl_prio[tbl_count] = it.prio;
                tbl_left[tbl_count] = it.burst;
                tbl_count++;
                res.accepted = 1'b1;
                n_stored++;
            end else begin
                n_refused++;
            end
        end else begin
            sched_time = sched_time + 16'd1;
            if (sched_time == 16'h0000) begin
                n_wraps++;
            end
            res.tick_time = sched_time;
            if (tbl_count > 0) begin
                best = 0;
                for (k = 1; k < tbl_count; k++) begin
                    if (tbl_prio[k] < tbl_prio[best]) begin
                        best = k;
                    end
                end
                res.ran_valid  = 1'b1;
                res.ran_pid    = tbl_pid[best];
                tbl_left[best] = tbl_left[best] - 16'd1;
                n_ran++;
                if (tbl_left[best] == 16'h0000) begin
                    res.finished = 1'b1;
                    n_done++;
                    for (k = best; k + 1 < tbl_count; k++) begin
                        tbl_pid[k]  = tbl_pid[k + 1];
                        tbl_prio[k] = tbl_prio[k + 1];
                        tbl_left[k] = tbl_left[k + 1];
                    end
                    tbl_count--;
                end
            end else begin
                n_idle++;
            end
        end
        expected_results.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result item %0d: %s is 0x%0h, expected 0x%0h",
                 items_checked, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_result(drv_item);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 &&
                    $urandom_range(99) >= tx_idle_pct[pending_items[0].phase]) begin
                    drv_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= drv_item.func;
                    s_tdata  <= {drv_item.burst, drv_item.prio, drv_item.pid};
                    rx_phase <= drv_item.phase;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        psched_pkg::result_t got;
        psched_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[26:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result item", m_tdata, 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
                    if (got.ran_valid !== want.ran_valid)
                        report_mismatch("ran_valid", 32'(got.ran_valid), 32'(want.ran_valid));
                    if (got.ran_pid !== want.ran_pid)
                        report_mismatch("ran_pid", 32'(got.ran_pid), 32'(want.ran_pid));
                    if (got.finished !== want.finished)
                        report_mismatch("finished", 32'(got.finished), 32'(want.finished));
                    if (got.tick_time !== want.tick_time)
                        report_mismatch("tick_time", 32'(got.tick_time), 32'(want.tick_time));
                    if (m_tdata[31:27] !== 5'b00000)
                        report_mismatch("padding", 32'(m_tdata[31:27]), 32'h0);
                end
                items_checked++;
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct[rx_phase]);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int i;
        int drain;

        // Idle tick, zero burst, field extremes, a task that finishes at once.
        add_item(psched_pkg::FUNC_TICK, 8'h00, 8'h00, 16'h0000, 0);
        add_item(psched_pkg::FUNC_ARRIVE, 8'h00, 8'h00, 16'h0000, 0);
        add_item(psched_pkg::FUNC_ARRIVE, 8'hFF, 8'hFF, 16'hFFFF, 0);
        add_item(psched_pkg::FUNC_ARRIVE, 8'h5A, 8'h00, 16'h0001, 0);
        add_item(psched_pkg::FUNC_TICK, 8'hFF, 8'hFF, 16'hFFFF, 0);
        add_item(psched_pkg::FUNC_TICK, 8'h00, 8'h00, 16'h0000, 0);
        // Fill the table with tied priorities, then one arrive too many.
        for (i = 0; i < 16; i++) begin
            add_item(psched_pkg::FUNC_ARRIVE, 8'(8'h10 + i), 8'(i % 3 + 1),
                     16'(i % 2 + 1), 0);
        end
        repeat (3) add_item(psched_pkg::FUNC_TICK, 8'h00, 8'h00, 16'h0000, 0);

        add_random_items(0, PHASE_ITEMS);
        add_random_items(1, PHASE_ITEMS);
        add_random_items(2, PHASE_ITEMS);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_tvalid) begin
            @(posedge aclk);
        end
        drain = 0;
        while (expected_results.size() > 0 && drain < 5000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (50) @(posedge aclk);
        if (expected_results.size() > 0) begin
            report_mismatch("result items never delivered",
                            32'(expected_results.size()), 32'h0);
        end

        $display("covered %0d arrives stored and %0d refused, %0d ticks with a task and %0d idle",
                 n_stored, n_refused, n_ran, n_idle);
        $display("%0d tasks completed, time counter wrapped %0d times, %0d result items checked",
                 n_done, n_wraps, items_checked);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
